/* rtl/assert_macros.svh */
// Assertion macros used by the top level of the tap tempo period estimator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clock, ignored while reset is high.
`define TTPE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked on every rising edge of clock, reset included.
`define TTPE_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

/* rtl/ttpe_pkg.sv */
// Package of the tap tempo period estimator: widths, codes, types.
package ttpe_pkg;

   localparam int TIME_W            = 32;
   localparam int PERIOD_W          = 32;
   localparam int PORTION_W         = 40;
   localparam int FRAC_W            = 8;
   localparam int DF_W              = 6;
   localparam int REP_W             = 6;
   localparam int CSR_IDX_W         = 2;
   localparam int CSR_DATA_W        = 6;

   localparam int TAP_HISTORY_DEPTH = 2;
   localparam int SLOT_W            = $clog2(TAP_HISTORY_DEPTH);
   localparam int FILL_W            = $clog2(TAP_HISTORY_DEPTH + 1);
   localparam int SUM_W             = TIME_W + $clog2(TAP_HISTORY_DEPTH);

   // shared serial divider: two quotient bits a cycle
   localparam int DIV_W             = PORTION_W;
   localparam int DIVISOR_W         = 6;
   localparam int DIV_DIGITS        = DIV_W / 2;
   localparam int DIV_CNT_W         = $clog2(DIV_DIGITS + 1);

   localparam int PROD_W            = PERIOD_W + DF_W - 1;

   localparam logic [PERIOD_W-1:0] MASTER_RESET = PERIOD_W'(120);
   localparam logic [REP_W-1:0]    REP_RESET    = REP_W'(1);
   localparam logic [REP_W-1:0]    REP_MIN      = REP_W'(1);
   localparam logic [REP_W-1:0]    REP_MAX      = REP_W'(32);

   localparam logic [CSR_IDX_W-1:0] CSR_DIVISION_FACTOR  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_REPETITION_COUNT = CSR_IDX_W'(1);

   localparam logic ACT_TAP  = 1'b0;
   localparam logic ACT_PING = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TRACK,
      ST_MEAN,
      ST_SCALE,
      ST_SCALE_DIV,
      ST_PORTION_START,
      ST_PORTION,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_W-1:0]     dividend;
      logic [DIVISOR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic              strobe;
      logic              action;
      logic [TIME_W-1:0] event_time;
   } trk_cmd_type;

   typedef struct packed {
      logic                 accepted;
      logic [DIV_W-1:0]     dividend;
      logic [DIVISOR_W-1:0] divisor;
   } trk_res_type;

endpackage

/* rtl/ttpe_req_if.sv */
// Event input channel: action and timestamp with valid/ready.
interface ttpe_req_if import ttpe_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              action;
   logic [TIME_W-1:0] event_time;

   modport source (output valid, output action, output event_time, input ready);
   modport sink   (input valid, input action, input event_time, output ready);
endinterface

/* rtl/ttpe_rsp_if.sv */
// Result channel: acceptance flag and the three period figures with valid/ready.
interface ttpe_rsp_if import ttpe_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 accepted;
   logic [PERIOD_W-1:0]  master_period_out;
   logic [PERIOD_W-1:0]  divided_period;
   logic [PORTION_W-1:0] step_portion;

   modport source (output valid, output accepted, output master_period_out,
                   output divided_period, output step_portion, input ready);
   modport sink   (input valid, input accepted, input master_period_out,
                   input divided_period, input step_portion, output ready);
endinterface

/* rtl/ttpe_csr_if.sv */
// Register write channel: index and data with valid/ready.
interface ttpe_csr_if import ttpe_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/tap_tempo_period_estimator.sv */
// Top level of the tap tempo period estimator: sequencer, settings, result register.
// Each tap or ping event gives one result; a rejected event skips the mean pass. The
// shared divider produces two quotient bits a cycle over a 40-bit dividend and runs
// once for an accepted event's new period, once for a negative division setting and
// once for the step portion. Events are taken one at a time; the next event is taken
// while the previous result still waits in the output register. Register writes may
// come at any time the block is idle and are taken at once. Nothing is taken while
// reset is high.
`include "assert_macros.svh"

module tap_tempo_period_estimator import ttpe_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   ttpe_req_if.sink   req,
   ttpe_rsp_if.source rsp,
   ttpe_csr_if.sink   csr
);

   state_type state_ff, state_in;

   logic [DF_W-1:0]      df_ff, df_in;
   logic [REP_W-1:0]     rep_ff, rep_in;
   logic [PERIOD_W-1:0]  master_ff, master_in;
   logic                 acc_ff, acc_in;
   logic [PERIOD_W-1:0]  divided_ff, divided_in;
   logic [PORTION_W-1:0] portion_ff, portion_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_acc_ff;
   logic [PERIOD_W-1:0]  rsp_master_ff;
   logic [PERIOD_W-1:0]  rsp_divided_ff;
   logic [PORTION_W-1:0] rsp_portion_ff;
   logic                 rsp_load;

   trk_cmd_type trk_cmd;
   trk_res_type trk_res;
   div_req_type div_req;
   div_rsp_type div_rsp;

   logic [PROD_W-1:0]    prod;
   logic [DIVISOR_W-1:0] df_mag;
   logic [REP_W-1:0]     reps;

   logic                 div_wait;
   logic                 rsp_stall;

   ttpe_tracker u_tracker (
      .clock   (clock),
      .reset   (reset),
      .trk_cmd (trk_cmd),
      .trk_res (trk_res)
   );

   ttpe_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req.ready = (state_ff == ST_IDLE) && !reset;
   assign csr.ready = !reset;

   assign trk_cmd.strobe     = req.valid && req.ready;
   assign trk_cmd.action     = req.action;
   assign trk_cmd.event_time = req.event_time;

   always_comb begin
      df_in  = df_ff;
      rep_in = rep_ff;
      if (csr.valid) begin
         case (csr.index)
            CSR_DIVISION_FACTOR:  df_in  = DF_W'(csr.data);
            CSR_REPETITION_COUNT: rep_in = REP_W'(csr.data);
            default: ;
         endcase
      end
   end

   always_comb begin
      prod   = PROD_W'(master_ff) * PROD_W'(df_ff[DF_W-2:0]);
      df_mag = DIVISOR_W'(-df_ff);
      if (rep_ff < REP_MIN)
         reps = REP_MIN;
      else if (rep_ff > REP_MAX)
         reps = REP_MAX;
      else
         reps = rep_ff;

      state_in         = state_ff;
      master_in        = master_ff;
      acc_in           = acc_ff;
      divided_in       = divided_ff;
      portion_in       = portion_ff;
      div_req.start    = 1'b0;
      div_req.dividend = trk_res.dividend;
      div_req.divisor  = trk_res.divisor;
      rsp_load         = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req.valid)
               state_in = ST_TRACK;
         end
         ST_TRACK: begin
            acc_in = trk_res.accepted;
            if (trk_res.accepted) begin
               div_req.start = 1'b1;
               state_in      = ST_MEAN;
            end else begin
               state_in = ST_SCALE;
            end
         end
         ST_MEAN: begin
            if (div_rsp.done) begin
               // period never drops below one millisecond
               master_in = (div_rsp.quotient[PERIOD_W-1:0] == '0) ? PERIOD_W'(1)
                                                                  : div_rsp.quotient[PERIOD_W-1:0];
               state_in  = ST_SCALE;
            end
         end
         ST_SCALE: begin
            if (df_ff[DF_W-1]) begin
               div_req.start    = 1'b1;
               div_req.dividend = DIV_W'(master_ff);
               div_req.divisor  = df_mag;
               state_in         = ST_SCALE_DIV;
            end else begin
               if (prod[PROD_W-1:PERIOD_W] != '0)
                  divided_in = '1;
               else if (df_ff == '0)
                  divided_in = master_ff;
               else
                  divided_in = prod[PERIOD_W-1:0];
               state_in = ST_PORTION_START;
            end
         end
         ST_SCALE_DIV: begin
            if (div_rsp.done) begin
               divided_in = div_rsp.quotient[PERIOD_W-1:0];
               state_in   = ST_PORTION_START;
            end
         end
         ST_PORTION_START: begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'({divided_ff, FRAC_W'(0)});
            div_req.divisor  = DIVISOR_W'(reps);
            state_in         = ST_PORTION;
         end
         ST_PORTION: begin
            if (div_rsp.done) begin
               portion_in = div_rsp.quotient[PORTION_W-1:0];
               state_in   = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (rsp_load)
         rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         df_ff        <= '0;
         rep_ff       <= REP_RESET;
         master_ff    <= MASTER_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         df_ff        <= df_in;
         rep_ff       <= rep_in;
         master_ff    <= master_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff     <= acc_in;
      divided_ff <= divided_in;
      portion_ff <= portion_in;
      if (rsp_load) begin
         rsp_acc_ff     <= acc_ff;
         rsp_master_ff  <= master_ff;
         rsp_divided_ff <= divided_ff;
         rsp_portion_ff <= portion_ff;
      end
   end

   assign rsp.valid             = rsp_valid_ff;
   assign rsp.accepted          = rsp_acc_ff;
   assign rsp.master_period_out = rsp_master_ff;
   assign rsp.divided_period    = rsp_divided_ff;
   assign rsp.step_portion      = rsp_portion_ff;

   assign div_wait  = (state_ff == ST_MEAN) || (state_ff == ST_SCALE_DIV) ||
                      (state_ff == ST_PORTION);
   assign rsp_stall = rsp.valid && !rsp.ready;

   `TTPE_ASSERT(a_master_nonzero, master_ff != '0, "master period fell to zero")
   `TTPE_ASSERT(a_div_done_expected, div_rsp.done |-> div_wait, "divider done while not waiting")
   `TTPE_ASSERT(a_rsp_from_output, $rose(rsp.valid) |-> ($past(state_ff) == ST_OUTPUT), "bad raise")
   `TTPE_ASSERT(a_no_overwrite, rsp_stall |-> !rsp_load, "pending result overwritten")

endmodule

/* rtl/ttpe_divider.sv */
// Serial restoring divider, two quotient bits a cycle, narrow divisor.
module ttpe_divider import ttpe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [DIV_W-1:0]     work_ff, work_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] dsr_ff, dsr_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 done_ff, done_in;

   logic [DIVISOR_W:0]   t1, t2;
   logic                 ge1, ge2;
   logic [DIVISOR_W-1:0] r1, r2;

   // remainder stays below the divisor, so it fits the divisor width
   always_comb begin
      t1  = {rem_ff, work_ff[DIV_W-1]};
      ge1 = t1 >= {1'b0, dsr_ff};
      r1  = ge1 ? DIVISOR_W'(t1 - {1'b0, dsr_ff}) : t1[DIVISOR_W-1:0];
      t2  = {r1, work_ff[DIV_W-2]};
      ge2 = t2 >= {1'b0, dsr_ff};
      r2  = ge2 ? DIVISOR_W'(t2 - {1'b0, dsr_ff}) : t2[DIVISOR_W-1:0];

      work_in = work_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         work_in = div_req.dividend;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
         cnt_in  = DIV_CNT_W'(DIV_DIGITS);
      end else if (cnt_ff != '0) begin
         work_in = {work_ff[DIV_W-3:0], ge1, ge2};
         rem_in  = r2;
         cnt_in  = cnt_ff - DIV_CNT_W'(1);
         done_in = (cnt_ff == DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = work_ff;

endmodule

/* rtl/ttpe_tracker.sv */
// Per-source interval tracking, outlier test and tap history with running sum.
module ttpe_tracker import ttpe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  trk_cmd_type trk_cmd,
   output trk_res_type trk_res
);

   logic [TIME_W-1:0] last_tap_ff, last_tap_in;
   logic [TIME_W-1:0] tap_int_ff, tap_int_in;
   logic [TIME_W-1:0] last_ping_ff, last_ping_in;
   logic [TIME_W-1:0] ping_int_ff, ping_int_in;
   logic [TIME_W-1:0] hist_ff [TAP_HISTORY_DEPTH];
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic              hist_we;

   logic                 acc_ff, acc_in;
   logic [DIV_W-1:0]     dvd_ff, dvd_in;
   logic [DIVISOR_W-1:0] dsr_ff, dsr_in;

   logic [TIME_W-1:0] dur, stored, last;
   logic              outlier, full;
   logic [FILL_W-1:0] fill_next;
   logic [SLOT_W-1:0] slot_next;
   logic [SUM_W-1:0]  sum_next;

   always_comb begin
      if (trk_cmd.action == ACT_PING) begin
         stored = ping_int_ff;
         last   = last_ping_ff;
      end else begin
         stored = tap_int_ff;
         last   = last_tap_ff;
      end
      dur = trk_cmd.event_time - last;
      // no previous event: both stored interval and last time are zero
      if (stored != '0)
         outlier = ({1'b0, dur} > {stored, 1'b0}) || (dur < (stored >> 1));
      else
         outlier = (last == '0);

      full      = (fill_ff == FILL_W'(TAP_HISTORY_DEPTH));
      fill_next = full ? fill_ff : fill_ff + FILL_W'(1);
      slot_next = (slot_ff == SLOT_W'(TAP_HISTORY_DEPTH - 1)) ? '0 : slot_ff + SLOT_W'(1);
      // sum covers exactly the filled entries; a full ring drops the overwritten one
      sum_next  = sum_ff + SUM_W'(dur) - (full ? SUM_W'(hist_ff[slot_ff]) : '0);

      last_tap_in  = last_tap_ff;
      tap_int_in   = tap_int_ff;
      last_ping_in = last_ping_ff;
      ping_int_in  = ping_int_ff;
      slot_in      = slot_ff;
      fill_in      = fill_ff;
      sum_in       = sum_ff;
      hist_we      = 1'b0;
      acc_in       = acc_ff;
      dvd_in       = dvd_ff;
      dsr_in       = dsr_ff;

      if (trk_cmd.strobe) begin
         acc_in = !outlier;
         if (trk_cmd.action == ACT_PING) begin
            last_ping_in = trk_cmd.event_time;
            ping_int_in  = outlier ? '0 : dur;
            dvd_in       = DIV_W'(dur);
            dsr_in       = DIVISOR_W'(1);
         end else begin
            last_tap_in = trk_cmd.event_time;
            if (outlier) begin
               tap_int_in = '0;
               slot_in    = '0;
               fill_in    = '0;
               sum_in     = '0;
            end else begin
               tap_int_in = dur;
               hist_we    = 1'b1;
               slot_in    = slot_next;
               fill_in    = fill_next;
               sum_in     = sum_next;
            end
            dvd_in = DIV_W'(sum_next);
            dsr_in = DIVISOR_W'(fill_next);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_tap_ff  <= '0;
         tap_int_ff   <= '0;
         last_ping_ff <= '0;
         ping_int_ff  <= '0;
         slot_ff      <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         acc_ff       <= 1'b0;
      end else begin
         last_tap_ff  <= last_tap_in;
         tap_int_ff   <= tap_int_in;
         last_ping_ff <= last_ping_in;
         ping_int_ff  <= ping_int_in;
         slot_ff      <= slot_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         acc_ff       <= acc_in;
      end
   end

   // history entries are only read once written since the last clear
   always_ff @(posedge clock) begin
      if (hist_we)
         hist_ff[slot_ff] <= dur;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign trk_res.accepted = acc_ff;
   assign trk_res.dividend = dvd_ff;
   assign trk_res.divisor  = dsr_ff;

endmodule
